[hw/rtl/pic_pkg.sv]
// ----------------------------------------------------------------------------
// pic_pkg: shared definitions for the priority interrupt controller
// Operation codes, register offsets, line widths and the item layouts.
// ----------------------------------------------------------------------------
package pic_pkg;

   localparam int NUM_LINES = 15;
   localparam int LINE_W    = NUM_LINES + 1;   // bit 0 unused, bits 1..NUM_LINES
   localparam int LNUM_W    = 4;
   localparam int RDATA_W   = 16;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [7:0] OFF_LEVEL   = 8'd0;
   localparam logic [7:0] OFF_PENDING = 8'd4;
   localparam logic [7:0] OFF_FORCE   = 8'd8;
   localparam logic [7:0] OFF_CLEAR   = 8'd12;
   localparam logic [7:0] OFF_STAT0   = 8'd16;
   localparam logic [7:0] OFF_STAT1   = 8'd20;
   localparam logic [7:0] OFF_MASK    = 8'd64;

   // Valid line bits: 1..NUM_LINES
   localparam logic [LINE_W-1:0] LINE_MASK = {{(LINE_W-1){1'b1}}, 1'b0};
   // The top line cannot be masked
   localparam logic [LINE_W-1:0] TOP_LINE  = {1'b1, {(LINE_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  addr;
      logic [31:0] wdata;
   } req_item_type;

   typedef struct packed {
      logic              irq_valid;
      logic [LNUM_W-1:0] irq_line;
      logic              bus_error;
      logic [RDATA_W-1:0] rdata;
   } rsp_item_type;

endpackage

[hw/rtl/priority_interrupt_controller_core.sv]
// ----------------------------------------------------------------------------
// priority_interrupt_controller_core: 15-line two-level interrupt controller
//
// Items arrive on the req_ stream: req_tuser carries the operation (read,
// write or tick), req_tdata the register offset and write data. Every item
// produces exactly one item on the rsp_ stream with the read data, a bus
// error flag and, for a tick, the selected interrupt line.
// An accepted item is held in the input register; decode, register
// update and priority selection work on it there and the result is
// registered in the result register, from which it is offered on rsp_.
// Throughput is one item per cycle while rsp_tready stays high: the input
// register takes a new item whenever its current item moves into the
// result register. The whole priority encode over the 15 lines is
// combinational logic between those two registers.
// When the receiver holds rsp_tready low, the result register holds its
// item, the input register fills, and req_tready drops until room frees.
// Reset clears the level, pending, force, mask and last-clear registers
// and empties both stages.
// ----------------------------------------------------------------------------
module priority_interrupt_controller_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] addr, [39:8] wdata
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [15:0] rdata, [16] bus_error, [17] irq_valid,
                                    // [21:18] irq_line, [23:22] zero
);

   localparam int LW = pic_pkg::LINE_W;

   logic                    item_valid_ff, item_valid_in;
   pic_pkg::req_item_type   item_ff, item_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pic_pkg::rsp_item_type   rsp_ff, rsp_in;

   logic [LW-1:0] level_ff,   level_in;
   logic [LW-1:0] pending_ff, pending_in;
   logic [LW-1:0] force_ff,   force_in;
   logic [LW-1:0] mask_ff,    mask_in;
   logic [LW-1:0] clear_ff,   clear_in;

   logic          accept_in_item;
   logic          advance;
   logic [LW-1:0] wdata_lim;
   logic [LW-1:0] hit_force;
   logic [LW-1:0] active;
   logic [LW-1:0] high_set;
   logic [LW-1:0] pick_set;
   logic          line_ok;

   function automatic logic [pic_pkg::LNUM_W-1:0] highest_line(input logic [LW-1:0] set);
      logic [pic_pkg::LNUM_W-1:0] n;
      n = '0;
      for (int i = 1; i < LW; i++) begin
         if (set[i]) begin
            n = pic_pkg::LNUM_W'(i);
         end
      end
      return n;
   endfunction

   assign advance        = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready     = !item_valid_ff || advance;
   assign accept_in_item = req_tvalid && req_tready;

   always_comb begin
      item_in.op    = req_tuser;
      item_in.addr  = req_tdata[7:0];
      item_in.wdata = req_tdata[39:8];
      if (accept_in_item) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   assign wdata_lim = item_ff.wdata[LW-1:0] & pic_pkg::LINE_MASK;
   assign hit_force = wdata_lim & force_ff;
   assign line_ok   = (item_ff.wdata[31:pic_pkg::LNUM_W] == '0)
                      && (item_ff.wdata[pic_pkg::LNUM_W-1:0] != '0);
   assign active    = (pending_ff | force_ff) & (mask_ff | pic_pkg::TOP_LINE)
                      & pic_pkg::LINE_MASK;
   assign high_set  = active & level_ff;
   assign pick_set  = (high_set != '0) ? high_set : active;

   always_comb begin
      level_in   = level_ff;
      pending_in = pending_ff;
      force_in   = force_ff;
      mask_in    = mask_ff;
      clear_in   = clear_ff;
      rsp_in     = '0;

      unique case (item_ff.op)
         pic_pkg::OP_READ: begin
            unique case (item_ff.addr)
               pic_pkg::OFF_LEVEL:   rsp_in.rdata = pic_pkg::RDATA_W'(level_ff);
               pic_pkg::OFF_PENDING: rsp_in.rdata = pic_pkg::RDATA_W'(pending_ff);
               pic_pkg::OFF_FORCE:   rsp_in.rdata = pic_pkg::RDATA_W'(force_ff);
               pic_pkg::OFF_CLEAR:   rsp_in.rdata = pic_pkg::RDATA_W'(clear_ff);
               pic_pkg::OFF_STAT0,
               pic_pkg::OFF_STAT1:   rsp_in.rdata = '0;
               pic_pkg::OFF_MASK:    rsp_in.rdata = pic_pkg::RDATA_W'(mask_ff);
               default:              rsp_in.bus_error = 1'b1;
            endcase
         end
         pic_pkg::OP_WRITE: begin
            unique case (item_ff.addr)
               pic_pkg::OFF_LEVEL: level_in = wdata_lim;
               pic_pkg::OFF_PENDING: begin
                  // Out-of-range line numbers are dropped silently
                  if (line_ok) begin
                     pending_in[item_ff.wdata[pic_pkg::LNUM_W-1:0]] = 1'b1;
                  end
               end
               pic_pkg::OFF_FORCE: force_in = wdata_lim;
               pic_pkg::OFF_CLEAR: begin
                  // Clear the force bit where set, else the pending bit
                  clear_in   = wdata_lim;
                  force_in   = force_ff & ~hit_force;
                  pending_in = pending_ff & ~(wdata_lim & ~hit_force);
               end
               pic_pkg::OFF_STAT0,
               pic_pkg::OFF_STAT1: ;
               pic_pkg::OFF_MASK: mask_in = wdata_lim;
               default:           rsp_in.bus_error = 1'b1;
            endcase
         end
         pic_pkg::OP_TICK: begin
            rsp_in.irq_line  = highest_line(pick_set);
            rsp_in.irq_valid = (pick_set != '0);
         end
         default: ;
      endcase
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         level_ff      <= '0;
         pending_ff    <= '0;
         force_ff      <= '0;
         mask_ff       <= '0;
         clear_ff      <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         // Commit register updates only as the item leaves the input stage
         if (advance) begin
            level_ff   <= level_in;
            pending_ff <= pending_in;
            force_ff   <= force_in;
            mask_ff    <= mask_in;
            clear_ff   <= clear_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in_item) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.irq_line, rsp_ff.irq_valid,
                        rsp_ff.bus_error, rsp_ff.rdata};

endmodule

[verif/priority_interrupt_controller_core_test.sv]
// ----------------------------------------------------------------------------
// priority_interrupt_controller_core_test: self-checking bench for the core
// Drives reads, writes and ticks into the req_ stream with random gaps and
// random rsp_ back-pressure. Keeps its own copy of the level, pending, force,
// mask and last-clear registers, predicts one response per accepted request
// and checks every response field in order.
// ----------------------------------------------------------------------------
module priority_interrupt_controller_core_test;

   localparam int         IDLE_LIMIT = 2000;
   localparam int         RAND_ITEMS = 1050;
   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam logic [7:0] OFF_BAD_HI = 8'hFF;
   localparam logic [7:0] OFF_BAD_LO = 8'h41;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // [7:0] addr, [39:8] wdata
   logic [1:0]  req_tuser  = '0;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [15:0] rdata, [16] bus_error, [17] irq_valid,
                                   // [21:18] irq_line, [23:22] zero

   // Shadow copy of the controller registers
   logic [pic_pkg::LINE_W-1:0] lvl_bits, pend_bits, frc_bits, msk_bits, clr_bits;

   pic_pkg::req_item_type req_backlog[$];
   pic_pkg::rsp_item_type rsp_due_q[$];
   pic_pkg::req_item_type next_req;
   pic_pkg::req_item_type seen_req;
   pic_pkg::rsp_item_type got_rsp;
   pic_pkg::rsp_item_type want_rsp;

   int  req_gap   = 0;
   bit  req_calm  = 1'b0;
   int  rsp_stall = 0;
   int  rsp_draw;
   bit  rsp_calm  = 1'b0;
   int  idle_cycles = 0;
   int  fail_count  = 0;

   priority_interrupt_controller_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // Apply one request to the shadow registers and return the response
   function automatic pic_pkg::rsp_item_type controller_step(pic_pkg::req_item_type it);
      logic [pic_pkg::LINE_W-1:0] d;
      logic [pic_pkg::LINE_W-1:0] hit;
      logic [pic_pkg::LINE_W-1:0] active;
      logic [pic_pkg::LINE_W-1:0] high;
      logic [pic_pkg::LINE_W-1:0] pick;
      pic_pkg::rsp_item_type      r;
      r = '0;
      d = it.wdata[pic_pkg::LINE_W-1:0] & pic_pkg::LINE_MASK;
      case (it.op)
         pic_pkg::OP_READ: begin
            case (it.addr)
               pic_pkg::OFF_LEVEL:   r.rdata = lvl_bits;
               pic_pkg::OFF_PENDING: r.rdata = pend_bits;
               pic_pkg::OFF_FORCE:   r.rdata = frc_bits;
               pic_pkg::OFF_CLEAR:   r.rdata = clr_bits;
               pic_pkg::OFF_STAT0,
               pic_pkg::OFF_STAT1:   r.rdata = '0;
               pic_pkg::OFF_MASK:    r.rdata = msk_bits;
               default:              r.bus_error = 1'b1;
            endcase
         end
         pic_pkg::OP_WRITE: begin
            case (it.addr)
               pic_pkg::OFF_LEVEL: lvl_bits = d;
               pic_pkg::OFF_PENDING: begin
                  if (it.wdata >= 1 && it.wdata <= pic_pkg::NUM_LINES)
                     pend_bits[it.wdata[pic_pkg::LNUM_W-1:0]] = 1'b1;
               end
               pic_pkg::OFF_FORCE: frc_bits = d;
               pic_pkg::OFF_CLEAR: begin
                  // a set bit drops force first, pending only where force was clear
                  clr_bits  = d;
                  hit       = d & frc_bits;
                  frc_bits  = frc_bits & ~hit;
                  pend_bits = pend_bits & ~(d & ~hit);
               end
               pic_pkg::OFF_STAT0,
               pic_pkg::OFF_STAT1: ;
               pic_pkg::OFF_MASK: msk_bits = d;
               default:           r.bus_error = 1'b1;
            endcase
         end
         pic_pkg::OP_TICK: begin
            active = (pend_bits | frc_bits) & (msk_bits | pic_pkg::TOP_LINE)
                     & pic_pkg::LINE_MASK;
            high   = active & lvl_bits;
            pick   = (high != '0) ? high : active;
            for (int n = pic_pkg::NUM_LINES; n >= 1; n--) begin
               if (pick[n] && r.irq_line == '0)
                  r.irq_line = pic_pkg::LNUM_W'(n);
            end
            r.irq_valid = (r.irq_line != '0);
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void queue_req(logic [1:0] op, logic [7:0] addr, logic [31:0] wdata);
      pic_pkg::req_item_type it;
      it.op    = op;
      it.addr  = addr;
      it.wdata = wdata;
      req_backlog.push_back(it);
   endfunction

   // Driver: hold the item until taken, then wait out the drawn gap
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap    <= req_gap - 1;
         end else if (req_backlog.size() != 0) begin
            next_req = req_backlog.pop_front();
            req_tuser  <= next_req.op;
            req_tdata  <= {next_req.wdata, next_req.addr};
            req_tvalid <= 1'b1;
            req_gap    <= req_calm ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 49) == 0)
               req_calm <= !req_calm;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure: after each accepted item, drop ready for a randomly drawn stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_draw = rsp_calm ? 0 : $urandom_range(0, 6);
         rsp_stall  <= rsp_draw;
         rsp_tready <= (rsp_draw == 0);
         if ($urandom_range(0, 49) == 0)
            rsp_calm <= !rsp_calm;
      end else if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= (rsp_stall == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on request accept, compare on response accept
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp.rdata     = rsp_tdata[15:0];
         got_rsp.bus_error = rsp_tdata[16];
         got_rsp.irq_valid = rsp_tdata[17];
         got_rsp.irq_line  = rsp_tdata[21:18];
         if (rsp_due_q.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want_rsp = rsp_due_q.pop_front();
            if (got_rsp.rdata !== want_rsp.rdata) begin
               $display("%0t: rdata expected %h got %h", $time, want_rsp.rdata, got_rsp.rdata);
               fail_count++;
            end
            if (got_rsp.bus_error !== want_rsp.bus_error) begin
               $display("%0t: bus_error expected %b got %b", $time,
                        want_rsp.bus_error, got_rsp.bus_error);
               fail_count++;
            end
            if (got_rsp.irq_valid !== want_rsp.irq_valid) begin
               $display("%0t: irq_valid expected %b got %b", $time,
                        want_rsp.irq_valid, got_rsp.irq_valid);
               fail_count++;
            end
            if (got_rsp.irq_line !== want_rsp.irq_line) begin
               $display("%0t: irq_line expected %0d got %0d", $time,
                        want_rsp.irq_line, got_rsp.irq_line);
               fail_count++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         seen_req.op    = req_tuser;
         seen_req.addr  = req_tdata[7:0];
         seen_req.wdata = req_tdata[39:8];
         rsp_due_q.push_back(controller_step(seen_req));
      end
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("priority_interrupt_controller_core_test: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [1:0]  op;
      logic [7:0]  addr;
      logic [31:0] wdata;
      int          pick;

      lvl_bits  = '0;
      pend_bits = '0;
      frc_bits  = '0;
      msk_bits  = '0;
      clr_bits  = '0;

      // Directed: extremes, unmaskable top line, force-before-pending clear,
      // ignored line numbers, status offsets, bad offsets, unused op
      queue_req(pic_pkg::OP_WRITE, pic_pkg::OFF_LEVEL,   32'hFFFF_FFFF);
      queue_req(pic_pkg::OP_WRITE, pic_pkg::OFF_MASK,    32'h0);
      queue_req(pic_pkg::OP_WRITE, pic_pkg::OFF_PENDING, 32'd15);
      queue_req(pic_pkg::OP_WRITE, pic_pkg::OFF_PENDING, 32'd0);
      queue_req(pic_pkg::OP_WRITE, pic_pkg::OFF_PENDING, 32'd16);
      queue_req(pic_pkg::OP_WRITE, pic_pkg::OFF_PENDING, 32'd1);
      queue_req(pic_pkg::OP_TICK,  8'h00,                32'h0);
      queue_req(pic_pkg::OP_WRITE, pic_pkg::OFF_FORCE,   32'hFFFF_AAAA);
      queue_req(pic_pkg::OP_WRITE, pic_pkg::OFF_CLEAR,   32'h0000_8002);
      queue_req(pic_pkg::OP_WRITE, pic_pkg::OFF_CLEAR,   32'h0000_0002);
      queue_req(pic_pkg::OP_READ,  pic_pkg::OFF_PENDING, 32'h0);
      queue_req(pic_pkg::OP_READ,  pic_pkg::OFF_FORCE,   32'h0);
      queue_req(pic_pkg::OP_READ,  pic_pkg::OFF_CLEAR,   32'h0);
      queue_req(pic_pkg::OP_WRITE, pic_pkg::OFF_MASK,    32'hFFFF_FFFF);
      queue_req(pic_pkg::OP_WRITE, pic_pkg::OFF_LEVEL,   32'h0000_0010);
      queue_req(pic_pkg::OP_TICK,  8'hFF,                32'hFFFF_FFFF);
      queue_req(pic_pkg::OP_WRITE, pic_pkg::OFF_STAT0,   32'h1234_5678);
      queue_req(pic_pkg::OP_READ,  pic_pkg::OFF_STAT1,   32'h0);
      queue_req(pic_pkg::OP_READ,  OFF_BAD_HI,           32'h0);
      queue_req(pic_pkg::OP_WRITE, OFF_BAD_LO,           32'hFFFF_FFFF);
      queue_req(pic_pkg::OP_WRITE, pic_pkg::OFF_FORCE,   32'h0);
      queue_req(pic_pkg::OP_WRITE, pic_pkg::OFF_CLEAR,   32'hFFFF_FFFF);
      queue_req(pic_pkg::OP_TICK,  8'h00,                32'h0);
      queue_req(OP_UNUSED,         pic_pkg::OFF_LEVEL,   32'hFFFF_FFFF);
      queue_req(pic_pkg::OP_READ,  pic_pkg::OFF_MASK,    32'h0);

      for (int i = 0; i < RAND_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)      op = pic_pkg::OP_READ;
         else if (pick < 72) op = pic_pkg::OP_WRITE;
         else if (pick < 99) op = pic_pkg::OP_TICK;
         else                op = OP_UNUSED;

         case ($urandom_range(0, 19))
            0, 1:   addr = pic_pkg::OFF_LEVEL;
            2, 3,
            4, 5:   addr = pic_pkg::OFF_PENDING;
            6, 7:   addr = pic_pkg::OFF_FORCE;
            8, 9,
            10:     addr = pic_pkg::OFF_CLEAR;
            11:     addr = pic_pkg::OFF_STAT0;
            12:     addr = pic_pkg::OFF_STAT1;
            13, 14,
            15:     addr = pic_pkg::OFF_MASK;
            default: addr = 8'($urandom_range(0, 255));
         endcase

         case ($urandom_range(0, 7))
            0:       wdata = 32'h0;
            1:       wdata = 32'hFFFF_FFFF;
            2:       wdata = $urandom();
            default: wdata = (addr == pic_pkg::OFF_PENDING) ? 32'($urandom_range(0, 16))
                                                             : $urandom();
         endcase
         queue_req(op, addr, wdata);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_tvalid || rsp_due_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (fail_count == 0 && rsp_due_q.size() == 0) begin
         $display("priority_interrupt_controller_core_test: PASS");
      end else begin
         $display("priority_interrupt_controller_core_test: FAIL");
      end
      $finish;
   end

endmodule
